FILE: hw/rtl/mme_pkg.sv
// Package for the matrix multiply engine: sizes, command and register codes,
// pipeline structs and the dimension clamp. No dependencies.
package mme_pkg;

  localparam int MAX_DIM     = 8;
  localparam int ELEM_BITS   = 16;
  localparam int IN_BITS     = 16;
  localparam int KEEP_BITS   = (ELEM_BITS < IN_BITS) ? ELEM_BITS : IN_BITS;
  localparam int DIM_W       = $clog2(MAX_DIM);
  localparam int DIMR_W      = 4;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = 6;
  localparam int ROW_W       = 3;
  localparam int PROD_W      = 2 * KEEP_BITS;
  localparam int SUM_W       = 35;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  // Control that travels with one multiply-accumulate term.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             lastk;
    logic             lastel;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } mme_tag_t;

  typedef struct packed {
    logic                 we_a;
    logic                 we_b;
    logic [ADDR_W-1:0]    addr;
    logic [KEEP_BITS-1:0] data;
  } mme_wr_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
  } mme_rd_t;

  // A dimension of zero acts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W:0] clamp_dim(input logic [DIMR_W-1:0] d);
    logic [DIM_W:0] r;
    if (d == '0) begin
      r = (DIM_W + 1)'(1);
    end else if (32'(d) > MAX_DIM) begin
      r = (DIM_W + 1)'(MAX_DIM);
    end else begin
      r = (DIM_W + 1)'(d);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/mme_store.sv
// Element stores for matrices A and B, one write port and one registered read each.
// Depends on mme_pkg.
module mme_store (
  input  logic                          clk,
  input  mme_pkg::mme_wr_t              wr,
  input  logic                          rd_en,
  input  mme_pkg::mme_rd_t              rd,
  output logic signed [mme_pkg::KEEP_BITS-1:0] rd_a,
  output logic signed [mme_pkg::KEEP_BITS-1:0] rd_b
);
  import mme_pkg::*;

  logic [KEEP_BITS-1:0] mem_a [STORE_DEPTH];
  logic [KEEP_BITS-1:0] mem_b [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we_a) begin
      mem_a[wr.addr] <= wr.data;
    end
    if (wr.we_b) begin
      mem_b[wr.addr] <= wr.data;
    end
  end

  // The read registers hold while the pipeline is frozen.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem_a[rd.addr_a];
      rd_b <= mem_b[rd.addr_b];
    end
  end

endmodule

FILE: hw/rtl/mme_mac.sv
// Shared multiply-accumulate unit with its tag pipeline and the result register.
// Depends on mme_pkg.
module mme_mac (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mme_pkg::mme_tag_t                     iss_tag,
  input  logic signed [mme_pkg::KEEP_BITS-1:0]  rd_a,
  input  logic signed [mme_pkg::KEEP_BITS-1:0]  rd_b,
  input  logic                                  out_stall,
  output logic                                  adv,
  output logic                                  out_valid,
  output logic [mme_pkg::ROW_W-1:0]             out_row,
  output logic [mme_pkg::ROW_W-1:0]             out_col,
  output logic signed [mme_pkg::SUM_W-1:0]      out_dot_sum,
  output logic                                  out_last
);
  import mme_pkg::*;

  mme_tag_t                  tag1_r;
  mme_tag_t                  tag2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   acc_r;
  logic signed [SUM_W-1:0]   acc_nxt;
  logic signed [SUM_W-1:0]   prod_ext;
  logic                      out_valid_r;
  logic [ROW_W-1:0]          out_row_r;
  logic [ROW_W-1:0]          out_col_r;
  logic signed [SUM_W-1:0]   out_sum_r;
  logic                      out_last_r;

  // The whole pipeline moves only when the result register can take a value.
  assign adv = !out_valid_r || !out_stall;

  assign prod_ext = SUM_W'(prod_r);
  assign acc_nxt  = tag2_r.first ? prod_ext : acc_r + prod_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r      <= '0;
      tag2_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      tag1_r      <= iss_tag;
      tag2_r      <= tag1_r;
      out_valid_r <= tag2_r.vld && tag2_r.lastk;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= rd_a * rd_b;
      if (tag2_r.vld) begin
        acc_r <= acc_nxt;
      end
      if (tag2_r.vld && tag2_r.lastk) begin
        out_sum_r  <= acc_nxt;
        out_row_r  <= ROW_W'(tag2_r.row);
        out_col_r  <= ROW_W'(tag2_r.col);
        out_last_r <= tag2_r.lastel;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_dot_sum = out_sum_r;
  assign out_last    = out_last_r;

endmodule

FILE: hw/rtl/mme_seq.sv
// Sequencer: takes input transfers, writes loads into the stores and steps the
// row, column and inner counters of a multiply. Depends on mme_pkg.
module mme_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [1:0]                      in_command,
  input  logic [mme_pkg::IDX_W-1:0]       in_elem_index,
  input  logic signed [15:0]              in_elem_value,
  output logic                            in_stall,
  input  logic [mme_pkg::DIMR_W-1:0]      rows_a,
  input  logic [mme_pkg::DIMR_W-1:0]      inner_dim,
  input  logic [mme_pkg::DIMR_W-1:0]      cols_b,
  input  logic                            adv,
  output mme_pkg::mme_wr_t                wr,
  output mme_pkg::mme_rd_t                rd,
  output mme_pkg::mme_tag_t               iss_tag
);
  import mme_pkg::*;

  state_t            state_r, state_nxt;
  logic [DIM_W-1:0]  i_r, i_nxt;
  logic [DIM_W-1:0]  j_r, j_nxt;
  logic [DIM_W-1:0]  k_r, k_nxt;
  logic [DIM_W-1:0]  m_m1_r, m_m1_nxt;
  logic [DIM_W-1:0]  n_m1_r, n_m1_nxt;
  logic [DIM_W-1:0]  p_m1_r, p_m1_nxt;
  logic [DIM_W:0]    n_r, n_nxt;
  logic [DIM_W:0]    p_r, p_nxt;
  logic [ADDR_W-1:0] a_base_r, a_base_nxt;
  logic [ADDR_W-1:0] b_ptr_r, b_ptr_nxt;
  logic [DIM_W:0]    m_c, n_c, p_c;
  logic              in_range;
  cmd_t              cmd;

  assign m_c = clamp_dim(rows_a);
  assign n_c = clamp_dim(inner_dim);
  assign p_c = clamp_dim(cols_b);
  assign cmd = cmd_t'(in_command);
  assign in_range = {1'b0, in_elem_index} < (IDX_W + 1)'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    k_r      <= k_nxt;
    m_m1_r   <= m_m1_nxt;
    n_m1_r   <= n_m1_nxt;
    p_m1_r   <= p_m1_nxt;
    n_r      <= n_nxt;
    p_r      <= p_nxt;
    a_base_r <= a_base_nxt;
    b_ptr_r  <= b_ptr_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    m_m1_nxt   = m_m1_r;
    n_m1_nxt   = n_m1_r;
    p_m1_nxt   = p_m1_r;
    n_nxt      = n_r;
    p_nxt      = p_r;
    a_base_nxt = a_base_r;
    b_ptr_nxt  = b_ptr_r;
    wr.we_a    = 1'b0;
    wr.we_b    = 1'b0;
    wr.addr    = in_elem_index[ADDR_W-1:0];
    wr.data    = in_elem_value[KEEP_BITS-1:0];
    in_stall   = (state_r != ST_IDLE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (cmd)
            CMD_LOAD_A: wr.we_a = in_range;
            CMD_LOAD_B: wr.we_b = in_range;
            CMD_START: begin
              m_m1_nxt   = DIM_W'(m_c - (DIM_W + 1)'(1));
              n_m1_nxt   = DIM_W'(n_c - (DIM_W + 1)'(1));
              p_m1_nxt   = DIM_W'(p_c - (DIM_W + 1)'(1));
              n_nxt      = n_c;
              p_nxt      = p_c;
              i_nxt      = '0;
              j_nxt      = '0;
              k_nxt      = '0;
              a_base_nxt = '0;
              b_ptr_nxt  = '0;
              state_nxt  = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // One term is issued per advancing cycle; A walks along a row, B down a column.
        if (adv) begin
          if (k_r == n_m1_r) begin
            k_nxt = '0;
            if (j_r == p_m1_r) begin
              j_nxt     = '0;
              b_ptr_nxt = '0;
              if (i_r == m_m1_r) begin
                state_nxt = ST_IDLE;
              end else begin
                i_nxt      = i_r + 1'b1;
                a_base_nxt = a_base_r + ADDR_W'(n_r);
              end
            end else begin
              j_nxt     = j_r + 1'b1;
              b_ptr_nxt = ADDR_W'(j_r) + ADDR_W'(1);
            end
          end else begin
            k_nxt     = k_r + 1'b1;
            b_ptr_nxt = b_ptr_r + ADDR_W'(p_r);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rd.addr_a = a_base_r + ADDR_W'(k_r);
  assign rd.addr_b = b_ptr_r;

  assign iss_tag.vld    = (state_r == ST_RUN);
  assign iss_tag.first  = (k_r == '0);
  assign iss_tag.lastk  = (k_r == n_m1_r);
  assign iss_tag.lastel = (i_r == m_m1_r) && (j_r == p_m1_r);
  assign iss_tag.row    = i_r;
  assign iss_tag.col    = j_r;

endmodule

FILE: hw/rtl/matrix_multiply_engine_unit.sv
// Matrix multiply engine: loads write one element each; a start issues one
// multiply-accumulate per cycle while the output is not stalled, on one shared
// multiplier, and takes no further input until the last term has issued. Each
// dot product leaves as one result, with its row and column, in row order.
// Reset clears control and sets all three dimensions to 8; the stores are not cleared.
module matrix_multiply_engine_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic [mme_pkg::IDX_W-1:0]         in_elem_index,
  input  logic signed [15:0]                in_elem_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mme_pkg::ROW_W-1:0]         out_row,
  output logic [mme_pkg::ROW_W-1:0]         out_col,
  output logic signed [mme_pkg::SUM_W-1:0]  out_dot_sum,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mme_pkg::DIMR_W-1:0]        cfg_data
);
  import mme_pkg::*;

  logic [DIMR_W-1:0]     rows_a_r;
  logic [DIMR_W-1:0]     inner_dim_r;
  logic [DIMR_W-1:0]     cols_b_r;
  logic                  adv;
  mme_wr_t               wr;
  mme_rd_t               rd;
  mme_tag_t              iss_tag;
  logic signed [KEEP_BITS-1:0] rd_a;
  logic signed [KEEP_BITS-1:0] rd_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DIMR_W'(MAX_DIM);
      inner_dim_r <= DIMR_W'(MAX_DIM);
      cols_b_r    <= DIMR_W'(MAX_DIM);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a_r    <= cfg_data;
        REG_INNER_DIM: inner_dim_r <= cfg_data;
        REG_COLS_B:    cols_b_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  mme_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_command    (in_command),
    .in_elem_index (in_elem_index),
    .in_elem_value (in_elem_value),
    .in_stall      (in_stall),
    .rows_a        (rows_a_r),
    .inner_dim     (inner_dim_r),
    .cols_b        (cols_b_r),
    .adv           (adv),
    .wr            (wr),
    .rd            (rd),
    .iss_tag       (iss_tag)
  );

  mme_store u_store (
    .clk   (clk),
    .wr    (wr),
    .rd_en (adv),
    .rd    (rd),
    .rd_a  (rd_a),
    .rd_b  (rd_b)
  );

  mme_mac u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .iss_tag     (iss_tag),
    .rd_a        (rd_a),
    .rd_b        (rd_b),
    .out_stall   (out_stall),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_dot_sum (out_dot_sum),
    .out_last    (out_last)
  );

  // Stores are never written while terms are being issued.
  a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we_a || wr.we_b) |-> !iss_tag.vld)
    else $error("store write during a multiply");

  // A start transfer makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_command == CMD_START)) |=> in_stall)
    else $error("start did not enter the run state");

  // A held result freezes the sequencer.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall && iss_tag.vld) |=> $stable(iss_tag))
    else $error("issue moved while the result register was stalled");

endmodule
